// ----- hw/rtl/bbl_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the battery bar level block.
// No dependencies; imported by every module of the block.
package bbl_pkg;

  localparam int MV_W           = 16;
  localparam int LEVEL_W        = 3;
  localparam int REARM_W        = 47;
  localparam int CFG_DATA_W     = 47;
  localparam int CFG_INDEX_W    = 3;
  localparam int CHARGE_WIDTH_DEF = 48;

  localparam logic [CFG_INDEX_W-1:0] CFG_BAR1_FLOOR   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BAR2_FLOOR   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BAR3_FLOOR   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BAR4_FLOOR   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_RISE_REARM   = 3'd4;

  localparam logic [MV_W-1:0]    BAR1_FLOOR_RST = 16'd2400;
  localparam logic [MV_W-1:0]    BAR2_FLOOR_RST = 16'd2480;
  localparam logic [MV_W-1:0]    BAR3_FLOOR_RST = 16'd2530;
  localparam logic [MV_W-1:0]    BAR4_FLOOR_RST = 16'd2575;
  localparam logic [REARM_W-1:0] RISE_REARM_RST = 47'd1000000000;

  localparam logic [LEVEL_W-1:0] LEVEL_EMPTY = 3'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_TWO   = 3'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_THREE = 3'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 3'd4;

  // Voltage floors as held by the configuration registers.
  typedef struct packed {
    logic [MV_W-1:0] bar1;
    logic [MV_W-1:0] bar2;
    logic [MV_W-1:0] bar3;
    logic [MV_W-1:0] bar4;
  } bbl_floors_t;

  // Result of the voltage evaluation for one item.
  typedef struct packed {
    logic [LEVEL_W-1:0] target;
    logic               rise_clear;
  } bbl_eval_t;

endpackage

// ----- hw/rtl/battery_bar_level_hysteresis.sv -----
`timescale 1ns / 1ps
// Battery bar level with rise hysteresis: one reference voltage in, one level out.
// Depends on bbl_pkg, bbl_cfg_regs, bbl_level_eval and bbl_level_state.
//
// One transaction in, one bar level out, at a sustained rate of one item per
// clock cycle while the output is not stalled. An accepted item is held in the
// input register, where the floor scan, threshold test and rearm compare run,
// and the committed level lands in the output register when the item advances.
// The rate is set by the committed-level and anchor registers, which each item
// reads and updates as it advances. Stalls on the output side hold both
// registers; the input side keeps taking items while the output register is
// free or being drained. Configuration writes are taken every cycle
// (cfg_ready is tied high) and must only be issued while no transaction is open.
module battery_bar_level_hysteresis #(
  parameter int CHARGE_WIDTH = bbl_pkg::CHARGE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bbl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bbl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bbl_pkg::MV_W-1:0]        sample_mv,
  input  logic                            charging,
  input  logic                            charge_trusted,
  input  logic [CHARGE_WIDTH-1:0]         session_charge,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bbl_pkg::LEVEL_W-1:0]     bar_level
);
  import bbl_pkg::*;

  bbl_floors_t             floors;
  logic [REARM_W-1:0]      rise_rearm_charge;
  bbl_eval_t               eval;
  logic [LEVEL_W-1:0]      level_next;

  logic                    s1_valid;
  logic [MV_W-1:0]         s1_mv;
  logic                    s1_charging;
  logic                    s1_charge_trusted;
  logic [CHARGE_WIDTH-1:0] s1_charge;
  logic                    advance;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;

  bbl_cfg_regs u_cfg (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .floors            (floors),
    .rise_rearm_charge (rise_rearm_charge)
  );

  bbl_level_eval u_eval (
    .sample_mv (s1_mv),
    .floors    (floors),
    .eval      (eval)
  );

  bbl_level_state #(
    .CHARGE_WIDTH (CHARGE_WIDTH)
  ) u_state (
    .clk               (clk),
    .rst               (rst),
    .step              (advance),
    .charging          (s1_charging),
    .charge_trusted    (s1_charge_trusted),
    .session_charge    (s1_charge),
    .eval              (eval),
    .rise_rearm_charge (rise_rearm_charge),
    .level_next        (level_next)
  );

  // Input register: load on acceptance, drop when the item advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mv             <= sample_mv;
      s1_charging       <= charging;
      s1_charge_trusted <= charge_trusted;
      s1_charge         <= session_charge;
    end
  end

  // Output register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bar_level <= level_next;
    end
  end

endmodule

// ----- hw/rtl/bbl_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration register file: four voltage floors and the rise rearm charge.
// Depends on bbl_pkg.
module bbl_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [bbl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bbl_pkg::CFG_DATA_W-1:0]  cfg_data,
  output bbl_pkg::bbl_floors_t           floors,
  output logic [bbl_pkg::REARM_W-1:0]    rise_rearm_charge
);
  import bbl_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      floors.bar1       <= BAR1_FLOOR_RST;
      floors.bar2       <= BAR2_FLOOR_RST;
      floors.bar3       <= BAR3_FLOOR_RST;
      floors.bar4       <= BAR4_FLOOR_RST;
      rise_rearm_charge <= RISE_REARM_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BAR1_FLOOR: floors.bar1       <= cfg_data[MV_W-1:0];
        CFG_BAR2_FLOOR: floors.bar2       <= cfg_data[MV_W-1:0];
        CFG_BAR3_FLOOR: floors.bar3       <= cfg_data[MV_W-1:0];
        CFG_BAR4_FLOOR: floors.bar4       <= cfg_data[MV_W-1:0];
        CFG_RISE_REARM: rise_rearm_charge <= cfg_data[REARM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/bbl_level_eval.sv -----
`timescale 1ns / 1ps
// Voltage evaluation: floor scan for the target level and the rise threshold test.
// Depends on bbl_pkg; purely combinational.
module bbl_level_eval (
  input  logic [bbl_pkg::MV_W-1:0] sample_mv,
  input  bbl_pkg::bbl_floors_t     floors,
  output bbl_pkg::bbl_eval_t       eval
);
  import bbl_pkg::*;

  logic [LEVEL_W-1:0]  target;
  logic [MV_W-1:0]     mid_lo;
  logic [MV_W-1:0]     mid_hi;
  logic signed [MV_W:0] mid_span;
  logic signed [MV_W:0] mid_half;
  logic [MV_W-1:0]     mid_th;
  logic [MV_W-1:0]     top_half;
  logic [MV_W:0]       top_sum;
  logic [MV_W:0]       rise_th;

  // Highest bar whose floor is met, scanning from the top.
  always_comb begin
    if (sample_mv >= floors.bar4) begin
      target = LEVEL_FULL;
    end else if (sample_mv >= floors.bar3) begin
      target = LEVEL_THREE;
    end else if (sample_mv >= floors.bar2) begin
      target = LEVEL_TWO;
    end else if (sample_mv >= floors.bar1) begin
      target = LEVEL_ONE;
    end else begin
      target = LEVEL_EMPTY;
    end
  end

  // Midpoint between floors t and t+1, halving toward zero.
  always_comb begin
    mid_lo   = (target == LEVEL_TWO) ? floors.bar2 : floors.bar3;
    mid_hi   = (target == LEVEL_TWO) ? floors.bar3 : floors.bar4;
    mid_span = $signed({1'b0, mid_hi}) - $signed({1'b0, mid_lo});
    mid_half = (mid_span + $signed({{MV_W{1'b0}}, mid_span[MV_W]})) >>> 1;
    mid_th   = mid_lo + mid_half[MV_W-1:0];
  end

  // Top level: floor 4 plus half the (non-negative) top spacing, saturated.
  always_comb begin
    top_half = (floors.bar4 > floors.bar3) ? ((floors.bar4 - floors.bar3) >> 1) : '0;
    top_sum  = {1'b0, floors.bar4} + {1'b0, top_half};
    if (top_sum[MV_W]) begin
      top_sum = {1'b0, {MV_W{1'b1}}};
    end
  end

  always_comb begin
    case (target)
      LEVEL_TWO, LEVEL_THREE: rise_th = {1'b0, mid_th};
      LEVEL_FULL:             rise_th = top_sum;
      default:                rise_th = {1'b0, floors.bar1};
    endcase
    eval.target     = target;
    eval.rise_clear = ({1'b0, sample_mv} >= rise_th);
  end

endmodule

// ----- hw/rtl/bbl_level_state.sv -----
`timescale 1ns / 1ps
// Committed level and rearm anchor, with the commit decision for each item.
// Depends on bbl_pkg and the evaluation from bbl_level_eval.
module bbl_level_state #(
  parameter int CHARGE_WIDTH = bbl_pkg::CHARGE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          charging,
  input  logic                          charge_trusted,
  input  logic [CHARGE_WIDTH-1:0]       session_charge,
  input  bbl_pkg::bbl_eval_t            eval,
  input  logic [bbl_pkg::REARM_W-1:0]   rise_rearm_charge,
  output logic [bbl_pkg::LEVEL_W-1:0]   level_next
);
  import bbl_pkg::*;

  localparam int CMP_W = (CHARGE_WIDTH + 1 > REARM_W) ? CHARGE_WIDTH + 1 : REARM_W;

  logic                    level_seeded;
  logic [LEVEL_W-1:0]      committed_level;
  logic                    anchor_valid;
  logic [CHARGE_WIDTH-1:0] anchor_charge;

  logic                    level_seeded_next;
  logic                    anchor_valid_next;
  logic [CHARGE_WIDTH-1:0] anchor_charge_next;

  logic                    eff_valid;
  logic [CHARGE_WIDTH-1:0] eff_charge;
  logic [CMP_W:0]          anchor_x;
  logic [CMP_W:0]          charge_x;
  logic [CMP_W:0]          discharge;
  logic [CMP_W:0]          rearm_x;
  logic                    rearmed;
  logic                    commit;

  // Latch the anchor when continuity first becomes valid.
  assign eff_valid  = anchor_valid | charge_trusted;
  assign eff_charge = (!anchor_valid && charge_trusted) ? session_charge : anchor_charge;

  assign anchor_x  = {{(CMP_W + 1 - CHARGE_WIDTH){eff_charge[CHARGE_WIDTH-1]}}, eff_charge};
  assign charge_x  = {{(CMP_W + 1 - CHARGE_WIDTH){session_charge[CHARGE_WIDTH-1]}},
                      session_charge};
  assign discharge = anchor_x - charge_x;
  assign rearm_x   = {{(CMP_W + 1 - REARM_W){1'b0}}, rise_rearm_charge};
  assign rearmed   = charge_trusted && eff_valid && !discharge[CMP_W] &&
                     (discharge >= rearm_x);

  always_comb begin
    if (!level_seeded) begin
      commit = 1'b1;
    end else if (eval.target <= committed_level) begin
      commit = (eval.target != committed_level);
    end else if ((eval.target == committed_level + LEVEL_ONE) && !eval.rise_clear) begin
      commit = 1'b0;
    end else begin
      commit = charging || rearmed;
    end
  end

  always_comb begin
    if (commit) begin
      level_next         = eval.target;
      level_seeded_next  = 1'b1;
      anchor_valid_next  = charge_trusted;
      anchor_charge_next = session_charge;
    end else begin
      level_next         = committed_level;
      level_seeded_next  = level_seeded;
      anchor_valid_next  = eff_valid;
      anchor_charge_next = eff_charge;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_seeded    <= 1'b0;
      committed_level <= LEVEL_EMPTY;
      anchor_valid    <= 1'b0;
      anchor_charge   <= '0;
    end else if (step) begin
      level_seeded    <= level_seeded_next;
      committed_level <= level_next;
      anchor_valid    <= anchor_valid_next;
      anchor_charge   <= anchor_charge_next;
    end
  end

  a_level_cap: assert property (@(posedge clk) disable iff (rst)
    committed_level <= LEVEL_FULL)
    else $error("committed level above full");

  a_seed_once: assert property (@(posedge clk) disable iff (rst)
    step && !level_seeded |=> level_seeded && committed_level == $past(eval.target))
    else $error("first transaction did not seed the level");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(committed_level) && $stable(anchor_valid))
    else $error("state moved without a transaction");

  a_drop_now: assert property (@(posedge clk) disable iff (rst)
    step && level_seeded && eval.target < committed_level
    |=> committed_level == $past(eval.target))
    else $error("level drop not committed at once");

endmodule
